// ----- hw/rtl/prtt_pkg.sv -----
package prtt_pkg;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_CLEAR  = 3'd2,
        MODE_LOOKUP = 3'd3,
        MODE_QUERY  = 3'd4
    } t_mode;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_STATE = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  source_state;
        logic [4:0]  target_state;
        logic [15:0] need_mask;
        logic [15:0] forbid_mask;
        logic signed [7:0] rule_priority;
        logic [3:0]  condition_number;
        logic [15:0] pressed_inputs;
        logic [14:0] condition_bits;
        logic        player_present;
    } t_req;

    typedef struct packed {
        logic [4:0] next_state;
        logic       hit;
        logic [1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [4:0]  src;
        logic [4:0]  dst;
        logic [15:0] need;
        logic [15:0] forbid;
        logic signed [7:0] prio;
        logic [3:0]  cond;
    } t_rule;

endpackage

// ----- hw/rtl/prtt_if.sv -----
interface prtt_req_if;
    logic            valid;
    logic            ready;
    prtt_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface prtt_rsp_if;
    logic            valid;
    logic            ready;
    prtt_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/prtt_front.sv -----
module prtt_front #(
    parameter int INPUT_BITS = 16,
    parameter int NUM_CONDITIONS = 15
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prtt_req_if.sink       i_req,
    output logic           o_valid,
    output prtt_pkg::t_req o_item,
    input  logic           i_ready
);
    // Two-entry queue; incoming items have their input and condition masks reduced here.
    prtt_pkg::t_req r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    prtt_pkg::t_req n_item;
    logic push, pop;

    localparam logic [15:0] IMASK = 16'((33'd1 << INPUT_BITS) - 33'd1);
    localparam logic [14:0] CMASK = 15'((16'd1 << NUM_CONDITIONS) - 16'd1);

    always_comb begin
        n_item = i_req.data;
        n_item.need_mask      = i_req.data.need_mask & IMASK;
        n_item.forbid_mask    = i_req.data.forbid_mask & IMASK;
        n_item.pressed_inputs = i_req.data.pressed_inputs & IMASK;
        n_item.condition_bits = i_req.data.condition_bits & CMASK;
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign push = i_req.valid && i_req.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_item = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_rd <= ~r_rd;
        end
        if (push) r_q[r_rd ^ r_cnt[0]] <= n_item;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> r_cnt == 2'd2)
        else $error("queue lost entry");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !o_valid)
        else $error("empty queue presents item");
endmodule

// ----- hw/rtl/prtt_back.sv -----
module prtt_back #(
    parameter int MAX_RULES = 32,
    parameter int NUM_STATES = 27,
    parameter int NUM_CONDITIONS = 15
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  prtt_pkg::t_req i_item,
    output logic           o_ready,
    prtt_rsp_if.source     o_rsp
);
    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_CHK, S_INS, S_DONE
    } t_state;

    prtt_pkg::t_rule r_mem [MAX_RULES];
    prtt_pkg::t_rule r_rdata;
    prtt_pkg::t_req  r_req;
    prtt_pkg::t_rsp  r_rsp;
    t_state    r_state;
    logic [CW-1:0] r_count, r_i, r_k;
    logic      r_out_v;
    prtt_pkg::t_rule new_rule;
    logic      fires, match_pair;
    logic [1:0] add_status;

    assign new_rule = '{src: r_req.source_state, dst: r_req.target_state,
                        need: r_req.need_mask, forbid: r_req.forbid_mask,
                        prio: r_req.rule_priority, cond: r_req.condition_number};

    always_comb begin
        fires = 1'b1;
        if (r_rdata.need != 16'd0 && (r_req.pressed_inputs & r_rdata.need) == 16'd0)
            fires = 1'b0;
        if ((r_req.pressed_inputs & r_rdata.forbid) != 16'd0) fires = 1'b0;
        if (r_rdata.cond != 4'd0) begin
            if (32'(r_rdata.cond) > NUM_CONDITIONS) fires = 1'b0;
            else if (!r_req.condition_bits[r_rdata.cond - 4'd1]) fires = 1'b0;
        end
    end
    assign match_pair = (r_rdata.src == r_req.source_state) &&
                        (r_rdata.dst == r_req.target_state);

    // An add with a bad state is refused before the capacity is looked at.
    always_comb begin
        add_status = prtt_pkg::STATUS_OK;
        if (i_item.mode == prtt_pkg::MODE_ADD) begin
            if (32'(i_item.source_state) >= NUM_STATES ||
                32'(i_item.target_state) >= NUM_STATES)
                add_status = prtt_pkg::STATUS_BAD_STATE;
            else if (32'(r_count) >= MAX_RULES)
                add_status = prtt_pkg::STATUS_FULL;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data = r_rsp;

    // Lookup/query walk reads each entry in S_RD and checks it in S_CHK. Remove compacts
    // in place (r_k write pointer). Add first finds the slot, then shifts the tail up
    // one entry a cycle starting from the top, and then writes the new rule into the slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req <= i_item;
                        r_i   <= '0;
                        r_k   <= '0;
                        r_rsp.hit <= 1'b0;
                        r_rsp.status <= add_status;
                        r_rsp.next_state <= (i_item.mode == prtt_pkg::MODE_LOOKUP) ?
                                            i_item.source_state : 5'd0;
                        case (i_item.mode)
                            prtt_pkg::MODE_ADD: begin
                                r_state <= (add_status != prtt_pkg::STATUS_OK) ?
                                           S_DONE : S_RD;
                            end
                            prtt_pkg::MODE_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            prtt_pkg::MODE_LOOKUP: begin
                                r_state <= i_item.player_present ? S_RD : S_DONE;
                            end
                            prtt_pkg::MODE_REMOVE, prtt_pkg::MODE_QUERY: r_state <= S_RD;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: begin
                    if (r_i >= r_count) begin
                        if (r_req.mode == prtt_pkg::MODE_REMOVE) r_count <= r_k;
                        if (r_req.mode == prtt_pkg::MODE_ADD) begin
                            r_k <= r_count;
                            r_state <= S_INS;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_rdata <= r_mem[r_i[AW-1:0]];
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    case (r_req.mode)
                        prtt_pkg::MODE_LOOKUP: begin
                            if (r_rdata.src == r_req.source_state && fires) begin
                                r_rsp.next_state <= r_rdata.dst;
                                r_rsp.hit <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_i <= r_i + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        prtt_pkg::MODE_QUERY: begin
                            if (match_pair) begin
                                r_rsp.hit <= 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_i <= r_i + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        prtt_pkg::MODE_REMOVE: begin
                            if (!match_pair) begin
                                r_mem[r_k[AW-1:0]] <= r_rdata;
                                r_k <= r_k + 1'b1;
                            end
                            r_i <= r_i + 1'b1;
                            r_state <= S_RD;
                        end
                        prtt_pkg::MODE_ADD: begin
                            if (r_rdata.prio < r_req.rule_priority) begin
                                r_k <= r_count;
                                r_state <= S_INS;
                            end else begin
                                r_i <= r_i + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_INS: begin
                    // r_i is the insert slot; r_k walks down from the count.
                    if (r_k == r_i) begin
                        r_mem[r_k[AW-1:0]] <= new_rule;
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_mem[r_k[AW-1:0]] <= r_mem[r_k[AW-1:0] - 1'b1];
                        r_k <= r_k - 1'b1;
                    end
                end
                S_DONE: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MAX_RULES) else $error("rule count over capacity");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_out_v) else $error("result not raised");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !o_ready) else $error("accepted with result pending");
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_rsp.status != 2'd3) else $error("bad status code");
endmodule

// ----- hw/rtl/priority_rule_transition_table.sv -----
// Clear, a lookup with no player and a rejected add go straight to the result;
// a walk reads and checks each rule in turn until it finds its match or slot or
// reaches the end of the table, and an add then shifts entries up and writes the rule.
// The back end takes one item at a time and accepts no new item until the result
// of the last one has been taken.
// Reset (synchronous, active low) empties the two-entry queue and the table.
module priority_rule_transition_table #(
    parameter int MAX_RULES = 32,
    parameter int NUM_STATES = 27,
    parameter int INPUT_BITS = 16,
    parameter int NUM_CONDITIONS = 15
) (
    input logic i_clk,
    input logic i_rst_n,
    prtt_req_if.sink   i_req,
    prtt_rsp_if.source o_rsp
);
    logic           q_valid, q_ready;
    prtt_pkg::t_req q_item;

    prtt_front #(.INPUT_BITS(INPUT_BITS),
                 .NUM_CONDITIONS(NUM_CONDITIONS)) u_front (
        .i_clk, .i_rst_n, .i_req,
        .o_valid(q_valid), .o_item(q_item), .i_ready(q_ready)
    );

    prtt_back #(.MAX_RULES(MAX_RULES), .NUM_STATES(NUM_STATES),
                .NUM_CONDITIONS(NUM_CONDITIONS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_item(q_item), .o_ready(q_ready), .o_rsp
    );
endmodule
